// ----- rtl/core/wlhm_pkg.sv -----
package wlhm_pkg;

  // default sizes
  localparam int RSSI_SLOTS_DEF = 5;
  localparam int DISC_SLOTS_DEF = 60;

  // divider operand widths
  localparam int DIV_NUM_W = 16;
  localparam int DIV_DEN_W = 8;

  // event commands
  localparam logic [2:0] CMD_TICK     = 3'd0;
  localparam logic [2:0] CMD_DISC     = 3'd1;
  localparam logic [2:0] CMD_SAMPLE   = 3'd2;
  localparam logic [2:0] CMD_SCAN_REC = 3'd3;
  localparam logic [2:0] CMD_SCAN_END = 3'd4;

  // report kinds
  localparam logic RPT_SAMPLE = 1'b0;
  localparam logic RPT_SCAN   = 1'b1;

  // limits
  localparam logic [15:0]       BUCKET_MAX   = 16'hFFFF;
  localparam logic [7:0]        COUNT_MAX    = 8'd255;
  localparam int                SCORE_MAX    = 100;
  localparam logic signed [8:0] CONTRIB_BASE = 9'sd100;
  localparam logic signed [7:0] RSSI_FLOOR   = -8'sd128;

  typedef struct packed {
    logic [2:0]        command;
    logic              connected;
    logic signed [7:0] rssi;
    logic [7:0]        chan_num;
  } evt_t;

  typedef struct packed {
    logic              report_kind;
    logic signed [7:0] level_avg;
    logic signed [7:0] level_min;
    logic [7:0]        cur_channel;
    logic [15:0]       disconnect_total;
    logic [7:0]        bss_on_channel;
    logic [7:0]        ap_seen;
    logic [6:0]        chan_load;
  } rpt_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BKT_INC,
    ST_SUM,
    ST_SCORE_DIV,
    ST_OUT
  } st_t;

endpackage

// ----- rtl/core/wifi_link_health_monitor.sv -----
// Sample beat: one bucket read per cycle sweeps the bucket ring into the disconnect sum; the
// window sum and the 16-step average divide overlap the sweep, and the report follows it.
// Scan end: the score uses the 16-step divider, skipped with no on-channel record; with no
// scan record no report is made. Tick, scan record and unused commands finish in idle.
// Disconnect adds a bucket increment. After reset a clearing pass zeroes the bucket ring;
// no beat is taken meanwhile. One event is worked at a time; a report waits in the output register.
module wifi_link_health_monitor #(
  parameter int RSSI_SLOTS = wlhm_pkg::RSSI_SLOTS_DEF,
  parameter int DISC_SLOTS = wlhm_pkg::DISC_SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           evt_valid,
  output logic           evt_ready,
  input  wlhm_pkg::evt_t evt,
  output logic           rpt_valid,
  input  logic           rpt_ready,
  output wlhm_pkg::rpt_t rpt
);
  import wlhm_pkg::*;

  localparam int WIN_AW = (RSSI_SLOTS > 1) ? $clog2(RSSI_SLOTS) : 1;
  localparam int FILL_W = $clog2(RSSI_SLOTS + 1);
  localparam int WSUM_W = 8 + FILL_W;
  localparam int BKT_AW = $clog2(DISC_SLOTS);
  localparam int BCNT_W = $clog2(DISC_SLOTS + 1);

  st_t state, state_next;

  // memories
  logic signed [7:0] win_mem [RSSI_SLOTS];
  logic signed [7:0] win_q;
  logic [15:0]       bkt_mem [DISC_SLOTS];
  logic [15:0]       bkt_q;

  logic              bkt_we;
  logic [BKT_AW-1:0] bkt_waddr;
  logic [15:0]       bkt_wdata;
  logic [BKT_AW-1:0] bkt_raddr;

  // architectural state
  logic [BKT_AW-1:0] bucket_pos;
  logic [BKT_AW-1:0] bucket_pos_next;
  logic [WIN_AW-1:0] window_pos;
  logic [FILL_W-1:0] window_fill;
  logic [7:0]        assoc_channel;
  logic [7:0]        scan_on;
  logic [7:0]        scan_all;
  logic [15:0]       scan_sum;

  // sweep state
  logic                     conn_r;
  logic [FILL_W-1:0]        win_idx;
  logic                     win_rd_vld;
  logic                     win_issue;
  logic                     win_done;
  logic [BCNT_W-1:0]        bkt_idx;
  logic                     bkt_rd_vld;
  logic                     bkt_issue;
  logic                     bkt_done;
  logic signed [WSUM_W-1:0] wsum;
  logic [WSUM_W-1:0]        wmag;
  logic signed [7:0]        cand;
  logic [15:0]              dsum;
  logic [16:0]              dsum_add;
  logic                     avg_go;
  logic                     avg_got;
  logic [7:0]               avg_mag;

  // scan contribution
  logic signed [8:0] rssi_adj;
  logic signed [8:0] contrib;

  logic     accept;
  logic     load_out;
  rpt_t     res;
  rpt_t     res_init;
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign accept = evt_valid && evt_ready;

  assign bucket_pos_next = (bucket_pos == BKT_AW'(DISC_SLOTS - 1)) ? '0 : bucket_pos + 1'b1;

  assign win_issue = conn_r && (win_idx < window_fill);
  assign win_done  = !win_issue && !win_rd_vld;
  assign bkt_issue = bkt_idx < BCNT_W'(DISC_SLOTS);
  assign bkt_done  = !bkt_issue && !bkt_rd_vld;

  assign wmag     = wsum[WSUM_W-1] ? (~wsum + 1'b1) : wsum;
  assign dsum_add = {1'b0, dsum} + {1'b0, bkt_q};
  assign avg_mag  = div_rsp.quo[7:0];

  // 100 + rssi / 2, rounding toward zero
  assign rssi_adj = $signed({evt.rssi[7], evt.rssi}) + $signed({8'b0, evt.rssi[7]});
  assign contrib  = CONTRIB_BASE + (rssi_adj >>> 1);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and control
  always_comb begin
    state_next = state;
    evt_ready  = 1'b0;
    load_out   = 1'b0;
    div_req    = '0;
    bkt_we     = 1'b0;
    bkt_waddr  = bucket_pos;
    bkt_wdata  = '0;
    bkt_raddr  = bucket_pos;
    case (state)
      ST_CLEAR: begin
        bkt_we    = 1'b1;
        bkt_waddr = bkt_idx[BKT_AW-1:0];
        if (bkt_idx == BCNT_W'(DISC_SLOTS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        evt_ready = 1'b1;
        if (evt_valid) begin
          case (evt.command)
            CMD_TICK: begin
              bkt_we    = 1'b1;
              bkt_waddr = bucket_pos_next;
            end
            CMD_DISC: begin
              state_next = ST_BKT_INC;
            end
            CMD_SAMPLE: begin
              state_next = ST_SUM;
            end
            CMD_SCAN_END: begin
              if (scan_all != '0) begin
                if (scan_on != '0) begin
                  div_req.start = 1'b1;
                  div_req.num   = scan_sum;
                  div_req.den   = scan_on;
                  state_next    = ST_SCORE_DIV;
                end else begin
                  state_next = ST_OUT;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_BKT_INC: begin
        bkt_we     = 1'b1;
        bkt_wdata  = (bkt_q == BUCKET_MAX) ? bkt_q : bkt_q + 1'b1;
        state_next = ST_IDLE;
      end
      ST_SUM: begin
        bkt_raddr = bkt_idx[BKT_AW-1:0];
        if (conn_r && win_done && !avg_go) begin
          div_req.start = 1'b1;
          div_req.num   = DIV_NUM_W'(wmag);
          div_req.den   = DIV_DEN_W'(window_fill);
        end
        if (bkt_done && (!conn_r || avg_got)) begin
          state_next = ST_OUT;
        end
      end
      ST_SCORE_DIV: begin
        if (div_rsp.done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!rpt_valid || rpt_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // bucket ring memory
  always_ff @(posedge clk) begin
    if (bkt_we) begin
      bkt_mem[bkt_waddr] <= bkt_wdata;
    end
    bkt_q <= bkt_mem[bkt_raddr];
  end

  // rssi window memory
  always_ff @(posedge clk) begin
    if (accept && evt.command == CMD_SAMPLE && evt.connected) begin
      win_mem[window_pos] <= evt.rssi;
    end
    win_q <= win_mem[win_idx[WIN_AW-1:0]];
  end

  // link and scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_pos    <= '0;
      window_pos    <= '0;
      window_fill   <= '0;
      assoc_channel <= '0;
      scan_on       <= '0;
      scan_all      <= '0;
      scan_sum      <= '0;
    end else if (accept) begin
      case (evt.command)
        CMD_TICK: begin
          bucket_pos <= bucket_pos_next;
        end
        CMD_SAMPLE: begin
          if (evt.connected) begin
            window_pos    <= (window_pos == WIN_AW'(RSSI_SLOTS - 1)) ? '0 : window_pos + 1'b1;
            assoc_channel <= evt.chan_num;
            if (window_fill != FILL_W'(RSSI_SLOTS)) begin
              window_fill <= window_fill + 1'b1;
            end
          end else begin
            assoc_channel <= '0;
          end
        end
        CMD_SCAN_REC: begin
          if (scan_all != COUNT_MAX) begin
            scan_all <= scan_all + 1'b1;
          end
          if (evt.chan_num == assoc_channel && scan_on != COUNT_MAX) begin
            scan_on  <= scan_on + 1'b1;
            scan_sum <= scan_sum + {8'b0, contrib[7:0]};
          end
        end
        CMD_SCAN_END: begin
          scan_on  <= '0;
          scan_all <= '0;
          scan_sum <= '0;
        end
        default: ;
      endcase
    end
  end

  // sweep counters and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      bkt_idx    <= '0;
      bkt_rd_vld <= 1'b0;
      win_idx    <= '0;
      win_rd_vld <= 1'b0;
      conn_r     <= 1'b0;
      avg_go     <= 1'b0;
      avg_got    <= 1'b0;
    end else if (state == ST_CLEAR) begin
      bkt_idx <= bkt_idx + 1'b1;
    end else if (accept && evt.command == CMD_SAMPLE) begin
      bkt_idx    <= '0;
      bkt_rd_vld <= 1'b0;
      win_idx    <= '0;
      win_rd_vld <= 1'b0;
      conn_r     <= evt.connected;
      avg_go     <= 1'b0;
      avg_got    <= 1'b0;
    end else if (state == ST_SUM) begin
      bkt_rd_vld <= bkt_issue;
      win_rd_vld <= win_issue;
      if (bkt_issue) begin
        bkt_idx <= bkt_idx + 1'b1;
      end
      if (win_issue) begin
        win_idx <= win_idx + 1'b1;
      end
      if (div_req.start) begin
        avg_go <= 1'b1;
      end
      if (avg_go && div_rsp.done) begin
        avg_got <= 1'b1;
      end
    end
  end

  // window and bucket accumulators
  always_ff @(posedge clk) begin
    if (accept && evt.command == CMD_SAMPLE) begin
      wsum <= '0;
      cand <= '0;
      dsum <= '0;
    end else if (state == ST_SUM) begin
      if (win_rd_vld) begin
        wsum <= wsum + $signed({{(WSUM_W-8){win_q[7]}}, win_q});
        if (cand == 8'sd0 || win_q < cand) begin
          cand <= win_q;
        end
      end
      if (bkt_rd_vld) begin
        dsum <= dsum_add[16] ? BUCKET_MAX : dsum_add[15:0];
      end
    end
  end

  // report fields known when the beat is taken
  always_comb begin
    res_init = '0;
    if (evt.command == CMD_SCAN_END) begin
      res_init.report_kind    = RPT_SCAN;
      res_init.bss_on_channel = scan_on;
      res_init.ap_seen        = scan_all;
    end else begin
      res_init.report_kind = RPT_SAMPLE;
      if (evt.connected) begin
        res_init.cur_channel = evt.chan_num;
      end else begin
        res_init.level_avg = RSSI_FLOOR;
        res_init.level_min = RSSI_FLOOR;
      end
    end
  end

  // pending report
  always_ff @(posedge clk) begin
    if (accept && (evt.command inside {CMD_SAMPLE, CMD_SCAN_END})) begin
      res <= res_init;
    end else if (state == ST_SUM) begin
      if (avg_go && div_rsp.done) begin
        res.level_avg <= wsum[WSUM_W-1] ? (~avg_mag + 8'd1) : avg_mag;
      end
      if (state_next == ST_OUT) begin
        res.disconnect_total <= dsum;
        if (conn_r) begin
          res.level_min <= cand;
        end
      end
    end else if (state == ST_SCORE_DIV && div_rsp.done) begin
      res.chan_load <= (div_rsp.quo > DIV_NUM_W'(SCORE_MAX)) ? 7'(SCORE_MAX)
                                                              : div_rsp.quo[6:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rpt_valid <= 1'b0;
    end else if (load_out) begin
      rpt_valid <= 1'b1;
    end else if (rpt_ready) begin
      rpt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rpt <= res;
    end
  end

  // shared divider for average and busy score
  wlhm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

endmodule

// ----- rtl/core/wlhm_div.sv -----
module wlhm_div (
  input  logic               clk,
  input  logic               rst,
  input  wlhm_pkg::div_req_t req,
  output wlhm_pkg::div_rsp_t rsp
);
  import wlhm_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W + 1);

  logic                 busy;
  logic                 done;
  logic [CNT_W-1:0]     cnt;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_NUM_W-1:0] quo;

  logic [DIV_DEN_W:0]   shifted;
  logic [DIV_DEN_W:0]   diff;
  logic                 fits;

  // one restoring step per cycle
  assign shifted = {rem, quo[DIV_NUM_W-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign fits    = shifted >= {1'b0, den_r};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo   <= req.num;
      rem   <= '0;
      den_r <= req.den;
    end else if (busy) begin
      rem <= fits ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
      quo <= {quo[DIV_NUM_W-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule
